@@ design/rfcf_pkg.sv @@
// Shared types, constants and helpers for the RF channel command framer.
package rfcf_pkg;

    // Field widths
    localparam int OP_W      = 1;
    localparam int CHAN_W    = 6;
    localparam int BYTE_W    = 8;
    localparam int REPEAT_W  = 3;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Default depth of the frame command queue
    localparam int CMDQ_DEPTH = 4;

    // Request kinds
    localparam logic [OP_W-1:0] OP_SET_CHANNEL = 1'b0;
    localparam logic [OP_W-1:0] OP_SET_MODE    = 1'b1;

    // Register map (word index taken from the byte address)
    localparam logic REG_REPEAT_COUNT = 1'b0;
    localparam logic [REPEAT_W-1:0] REPEAT_RESET = 3'd3;
    localparam logic [REPEAT_W-1:0] REPEAT_MIN   = 3'd1;
    localparam logic [REPEAT_W-1:0] REPEAT_MAX   = 3'd6;

    // Highest legal channel index
    localparam logic [CHAN_W-1:0] MAX_INDEX = 6'd55;

    // Frame bytes
    localparam logic [BYTE_W-1:0] LETTER_BAND    = 8'h42; // 'B'
    localparam logic [BYTE_W-1:0] LETTER_CHANNEL = 8'h43; // 'C'
    localparam logic [BYTE_W-1:0] LETTER_MODE    = 8'h44; // 'D'
    localparam logic [BYTE_W-1:0] FRAME_EQUALS   = 8'h3D; // '='
    localparam logic [BYTE_W-1:0] FRAME_ONE      = 8'h01;
    localparam logic [BYTE_W-1:0] ERROR_BYTE     = 8'h00;

    // Byte positions within a frame
    localparam int POS_W = 3;
    localparam logic [POS_W-1:0] POS_LETTER   = 3'd0;
    localparam logic [POS_W-1:0] POS_EQUALS   = 3'd1;
    localparam logic [POS_W-1:0] POS_ONE      = 3'd2;
    localparam logic [POS_W-1:0] POS_CHECKSUM = 3'd3;
    localparam logic [POS_W-1:0] POS_PAYLOAD  = 3'd4;

    // One frame to send, as queued between front and back
    typedef struct packed {
        logic [BYTE_W-1:0] letter;
        logic [BYTE_W-1:0] payload;
        logic [BYTE_W-1:0] checksum;
        logic              last_frame;
        logic              error;
    } frame_cmd_t;

    // Band remap table
    function automatic logic [BYTE_W-1:0] band_remap(input logic [2:0] band);
        logic [BYTE_W-1:0] value;
        unique case (band)
            3'd0:    value = 8'd5;
            3'd1:    value = 8'd4;
            3'd2:    value = 8'd3;
            3'd3:    value = 8'd1;
            3'd4:    value = 8'd2;
            3'd5:    value = 8'd6;
            default: value = 8'd7;
        endcase
        return value;
    endfunction

    // Build a frame command with its 8-bit sum checksum
    function automatic frame_cmd_t make_frame(input logic [BYTE_W-1:0] letter,
                                              input logic [BYTE_W-1:0] payload,
                                              input logic              last_frame);
        frame_cmd_t cmd;
        cmd.letter     = letter;
        cmd.payload    = payload;
        cmd.checksum   = letter + FRAME_EQUALS + FRAME_ONE + payload;
        cmd.last_frame = last_frame;
        cmd.error      = 1'b0;
        return cmd;
    endfunction

endpackage

@@ design/rfcf_if.sv @@
// Request and result channel interfaces of the RF channel command framer.
interface rfcf_req_if;
    import rfcf_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [CHAN_W-1:0] channel_index;
    logic [BYTE_W-1:0] mode_value;

    modport source (output valid, output op, output channel_index, output mode_value,
                    input ready);
    modport sink   (input valid, input op, input channel_index, input mode_value,
                    output ready);
endinterface

interface rfcf_res_if;
    import rfcf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              frame_end;
    logic              last;
    logic              error;

    modport source (output valid, output out_byte, output frame_end, output last,
                    output error, input ready);
    modport sink   (input valid, input out_byte, input frame_end, input last,
                    input error, output ready);
endinterface

@@ design/rfcf_front.sv @@
// Front end: accepts requests, checks the index and queues frame commands.
module rfcf_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    rfcf_req_if.sink             req,
    output rfcf_pkg::frame_cmd_t push_cmd,
    output logic                 push_valid,
    input  logic                 cmdq_full
);
    import rfcf_pkg::*;

    logic       accept;
    logic       index_bad;
    frame_cmd_t first_cmd;
    frame_cmd_t chan_cmd;
    logic       pend_valid_reg;
    logic       pend_valid_next;
    frame_cmd_t pend_cmd_reg;
    frame_cmd_t pend_cmd_next;

    // Take a new request only when no channel frame waits and the queue has room
    assign req.ready = !pend_valid_reg && !cmdq_full;
    assign accept    = req.valid && req.ready;
    assign index_bad = req.channel_index > MAX_INDEX;

    // Classify the request into its first frame command
    always_comb
    begin
        chan_cmd = make_frame(LETTER_CHANNEL,
                              {{(BYTE_W-3){1'b0}}, req.channel_index[2:0]} + 8'd1, 1'b1);
        if (req.op == OP_SET_MODE)
        begin
            first_cmd = make_frame(LETTER_MODE, req.mode_value, 1'b1);
        end
        else if (index_bad)
        begin
            first_cmd            = '0;
            first_cmd.last_frame = 1'b1;
            first_cmd.error      = 1'b1;
        end
        else
        begin
            first_cmd = make_frame(LETTER_BAND, band_remap(req.channel_index[5:3]), 1'b0);
        end
    end

    // Push the held channel frame first, else the first frame of a new request
    always_comb
    begin
        push_valid      = 1'b0;
        push_cmd        = first_cmd;
        pend_valid_next = pend_valid_reg;
        pend_cmd_next   = pend_cmd_reg;
        if (pend_valid_reg)
        begin
            push_cmd = pend_cmd_reg;
            if (!cmdq_full)
            begin
                push_valid      = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            push_valid = 1'b1;
            if (req.op == OP_SET_CHANNEL && !index_bad)
            begin
                pend_valid_next = 1'b1;
                pend_cmd_next   = chan_cmd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_cmd_reg <= pend_cmd_next;
    end

endmodule

@@ design/rfcf_cmdq.sv @@
// Short queue of frame commands between front and back.
module rfcf_cmdq
#(
    parameter int DEPTH = rfcf_pkg::CMDQ_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rfcf_pkg::frame_cmd_t push_cmd,
    input  logic                 push_valid,
    output logic                 full,
    output rfcf_pkg::frame_cmd_t head_cmd,
    output logic                 head_valid,
    input  logic                 pop
);
    import rfcf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_cmd_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers with wrap and track occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ design/rfcf_back.sv @@
// Back end: walks each queued frame byte by byte, repeated, into the output register.
module rfcf_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [rfcf_pkg::REPEAT_W-1:0]       repeat_count,
    input  rfcf_pkg::frame_cmd_t                head_cmd,
    input  logic                                head_valid,
    output logic                                pop,
    rfcf_res_if.source                          res
);
    import rfcf_pkg::*;

    logic [REPEAT_W-1:0] reps_eff;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [REPEAT_W-1:0] rep_reg;
    logic [REPEAT_W-1:0] rep_next;
    logic                advance;
    logic                fire;
    logic                frame_done;
    logic                last_rep;
    logic [BYTE_W-1:0]   byte_sel;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_frame_end_reg;
    logic                out_last_reg;
    logic                out_error_reg;

    // Clamp the repeat count into its legal range
    always_comb
    begin
        if (repeat_count < REPEAT_MIN)
        begin
            reps_eff = REPEAT_MIN;
        end
        else if (repeat_count > REPEAT_MAX)
        begin
            reps_eff = REPEAT_MAX;
        end
        else
        begin
            reps_eff = repeat_count;
        end
    end

    assign advance    = !out_valid_reg || res.ready;
    assign fire       = head_valid && advance;
    assign frame_done = pos_reg == POS_PAYLOAD;
    assign last_rep   = rep_reg == reps_eff - 1'b1;
    assign pop        = fire && (head_cmd.error || (frame_done && last_rep));

    // Select the frame byte at the current position
    always_comb
    begin
        unique case (pos_reg)
            POS_LETTER:   byte_sel = head_cmd.letter;
            POS_EQUALS:   byte_sel = FRAME_EQUALS;
            POS_ONE:      byte_sel = FRAME_ONE;
            POS_CHECKSUM: byte_sel = head_cmd.checksum;
            POS_PAYLOAD:  byte_sel = head_cmd.payload;
            default:      byte_sel = ERROR_BYTE;
        endcase
    end

    // Step position and repetition counters
    always_comb
    begin
        pos_next = pos_reg;
        rep_next = rep_reg;
        if (fire)
        begin
            if (pop)
            begin
                pos_next = POS_LETTER;
                rep_next = '0;
            end
            else if (frame_done)
            begin
                pos_next = POS_LETTER;
                rep_next = rep_reg + 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // Hold the output beat until taken
    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_LETTER;
            rep_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            rep_reg       <= rep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the output payload on each new beat
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg      <= head_cmd.error ? ERROR_BYTE : byte_sel;
            out_frame_end_reg <= !head_cmd.error && frame_done;
            out_last_reg      <= head_cmd.error || (head_cmd.last_frame && frame_done && last_rep);
            out_error_reg     <= head_cmd.error;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.out_byte  = out_byte_reg;
    assign res.frame_end = out_frame_end_reg;
    assign res.last      = out_last_reg;
    assign res.error     = out_error_reg;

endmodule

@@ design/rf_channel_command_framer_top.sv @@
// RF channel command framer: request in, command frame bytes out, APB register port.
//
// A set-channel request produces a band frame and a channel frame, a set-mode request
// one mode frame; each 5-byte frame goes out repeat_count times (clamped to 1..6), so a
// request yields 10*R or 5*R result beats and an out-of-range index yields one error
// beat. The back end emits one beat per cycle from the head of a frame command queue
// while the result channel is not stalled; that byte walk is what sets the sustained
// rate. The front end takes a new request in any cycle in which the queue has room and
// no channel frame is still waiting to be queued, so requests queue up while earlier
// ones are still sent.
module rf_channel_command_framer_top
#(
    parameter int CMDQ_DEPTH = rfcf_pkg::CMDQ_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rfcf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rfcf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rfcf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    rfcf_req_if.sink                          req,
    rfcf_res_if.source                        res
);
    import rfcf_pkg::*;

    logic [REPEAT_W-1:0] repeat_count_reg;
    logic [REPEAT_W-1:0] repeat_count_next;
    logic                cfg_write;
    frame_cmd_t          push_cmd;
    logic                push_valid;
    logic                cmdq_full;
    frame_cmd_t          head_cmd;
    logic                head_valid;
    logic                pop;

    // Register write on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        repeat_count_next = repeat_count_reg;
        if (cfg_write && paddr[2] == REG_REPEAT_COUNT)
        begin
            repeat_count_next = pwdata[REPEAT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_count_reg <= REPEAT_RESET;
        end
        else
        begin
            repeat_count_reg <= repeat_count_next;
        end
    end

    // Read back the register, zero elsewhere
    assign prdata = (paddr[2] == REG_REPEAT_COUNT)
                  ? {{(APB_DATA_W-REPEAT_W){1'b0}}, repeat_count_reg}
                  : '0;

    rfcf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .cmdq_full  (cmdq_full)
    );

    rfcf_cmdq
    #(
        .DEPTH (CMDQ_DEPTH)
    )
    u_cmdq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .full       (cmdq_full),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .pop        (pop)
    );

    rfcf_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .repeat_count (repeat_count_reg),
        .head_cmd     (head_cmd),
        .head_valid   (head_valid),
        .pop          (pop),
        .res          (res)
    );

endmodule

@@ design/rfcf_checker.sv @@
// Port-level checker for the RF channel command framer, bound to the top level.
module rfcf_checker
(
    input logic clk,
    input logic rst_n,
    input logic pready,
    input logic res_valid,
    input logic res_ready,
    input logic [7:0] res_out_byte,
    input logic res_frame_end,
    input logic res_last,
    input logic res_error
);

    // Hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_out_byte) && $stable(res_frame_end)
                                    && $stable(res_last) && $stable(res_error))
        else $error("result payload changed while stalled");

    // Error beat is a lone, closing beat with a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_error |-> res_last && !res_frame_end && res_out_byte == 8'h00)
        else $error("malformed error beat");

    // A normal request always closes on the end of a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_last && !res_error |-> res_frame_end)
        else $error("request closed mid-frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready deasserted");

endmodule

bind rf_channel_command_framer_top rfcf_checker u_rfcf_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .pready        (pready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_out_byte  (res.out_byte),
    .res_frame_end (res.frame_end),
    .res_last      (res.last),
    .res_error     (res.error)
);
